[rtl/bme_pkg.sv]
// Shared types, constants and helper functions for the bicycle model integrator.
// Used by every module of the block; depends on nothing.
package bme_pkg;

   localparam int MAX_STEPS       = 64;
   localparam int TRIG_ITERATIONS = 20;
   localparam int DIV_BITS        = 56;

   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [67:0] TWO_PI_Q20  = 68'sd6588397;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_INV_WHEELBASE = 2'd0;
   localparam logic [1:0] REG_TIME_STEP     = 2'd1;
   localparam logic [1:0] REG_INV_TIME_STEP = 2'd2;

   // Operand selection codes of the shared multiplier.
   localparam logic [2:0] MUL_V_INVL = 3'd0;
   localparam logic [2:0] MUL_W_SNT  = 3'd1;
   localparam logic [2:0] MUL_ACC    = 3'd2;
   localparam logic [2:0] MUL_V_CS   = 3'd3;
   localparam logic [2:0] MUL_V_SN   = 3'd4;
   localparam logic [2:0] MUL_RX_DT  = 3'd5;
   localparam logic [2:0] MUL_RY_DT  = 3'd6;
   localparam logic [2:0] MUL_RH_DT  = 3'd7;

   typedef struct packed {
      logic       capture;
      logic       load_state;
      logic       trig_start;
      logic       trig_heading;
      logic       cap_trig_steer;
      logic       cap_trig_head;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       div_start;
      logic       cap_rh;
      logic       cap_accel;
      logic       cap_rx;
      logic       cap_ry;
      logic       cap_nx;
      logic       cap_ny;
      logic       cap_nh;
      logic       out_load;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic trig_done;
      logic div_done;
      logic out_busy;
   } dp_status_type;

   function automatic logic [30:0] atan_val(input logic [4:0] idx);
      logic [30:0] r;
      case (idx)
         5'd0:  r = 31'h3243F6A8;
         5'd1:  r = 31'h1DAC6705;
         5'd2:  r = 31'h0FADBAFC;
         5'd3:  r = 31'h07F56EA6;
         5'd4:  r = 31'h03FEAB76;
         5'd5:  r = 31'h01FFD55B;
         5'd6:  r = 31'h00FFFAAA;
         5'd7:  r = 31'h007FFF55;
         5'd8:  r = 31'h003FFFEA;
         5'd9:  r = 31'h001FFFFD;
         5'd10: r = 31'h000FFFFF;
         5'd11: r = 31'h0007FFFF;
         5'd12: r = 31'h0003FFFF;
         5'd13: r = 31'h0001FFFF;
         5'd14: r = 31'h0000FFFF;
         5'd15: r = 31'h00007FFF;
         5'd16: r = 31'h00003FFF;
         5'd17: r = 31'h00001FFF;
         5'd18: r = 31'h00000FFF;
         5'd19: r = 31'h000007FF;
         5'd20: r = 31'h000003FF;
         5'd21: r = 31'h000001FF;
         5'd22: r = 31'h000000FF;
         5'd23: r = 31'h0000007F;
         default: r = 31'h0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [67:0] v);
      logic [31:0] r;
      if (v > 68'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -68'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [23:0] sat24(input logic signed [67:0] v);
      logic [23:0] r;
      if (v > 68'sd8388607) r = 24'h7F_FFFF;
      else if (v < -68'sd8388608) r = 24'h80_0000;
      else r = v[23:0];
      return r;
   endfunction

   function automatic logic [22:0] sat23(input logic signed [67:0] v);
      logic [22:0] r;
      if (v > 68'sd4194303) r = 23'h3F_FFFF;
      else if (v < -68'sd4194304) r = 23'h40_0000;
      else r = v[22:0];
      return r;
   endfunction

endpackage

[rtl/bme_if.sv]
// Valid/ready channel interfaces for the command and result transfers.
// Depends on nothing.
interface bme_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [23:0] heading;
   logic signed [22:0] speed;
   logic signed [31:0] accel_in;
   logic signed [20:0] steer;
   logic [6:0]         steps;

   modport source (output valid, mode, pos_x, pos_y, heading, speed, accel_in, steer, steps,
                   input ready);
   modport sink (input valid, mode, pos_x, pos_y, heading, speed, accel_in, steer, steps,
                 output ready);
endinterface

interface bme_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [23:0] out_heading;
   logic signed [22:0] rate_x;
   logic signed [22:0] rate_y;
   logic signed [31:0] rate_heading;
   logic signed [22:0] out_speed;
   logic signed [31:0] out_accel;
   logic               last;

   modport source (output valid, out_x, out_y, out_heading, rate_x, rate_y, rate_heading,
                   out_speed, out_accel, last, input ready);
   modport sink (input valid, out_x, out_y, out_heading, rate_x, rate_y, rate_heading,
                 out_speed, out_accel, last, output ready);
endinterface

[rtl/bicycle_model_euler_integrator.sv]
// Kinematic bicycle model with Euler steps. A load command gives no result. A drive command
// first runs a setup (steering CORDIC, 56-bit divider), then for each step a 20-iteration
// CORDIC on the heading plus the shared-multiplier products for the rates and the new pose.
// One command is worked on at a time; a new one is taken once the last result is in the output register.
// Synchronous active-high reset clears the pose state, the control state and restores the
// configuration registers to their defaults.
module bicycle_model_euler_integrator (
   input  logic        clock,
   input  logic        reset,
   bme_req_if.sink     req_chan,
   bme_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bme_pkg::*;

   logic [23:0]   inv_wb_ff, dt_ff, inv_dt_ff;
   logic          csr_write;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_wb_ff <= 24'd559241;
         dt_ff     <= 24'd6554;
         inv_dt_ff <= 24'd2560;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_INV_WHEELBASE: inv_wb_ff <= csr_pwdata[23:0];
            REG_TIME_STEP:     dt_ff     <= csr_pwdata[23:0];
            REG_INV_TIME_STEP: inv_dt_ff <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_INV_WHEELBASE: csr_prdata = {8'b0, inv_wb_ff};
         REG_TIME_STEP:     csr_prdata = {8'b0, dt_ff};
         REG_INV_TIME_STEP: csr_prdata = {8'b0, inv_dt_ff};
         default:           csr_prdata = '0;
      endcase
   end

   bme_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_mode  (req_chan.mode),
      .req_steps (req_chan.steps),
      .status    (status),
      .cmd       (cmd)
   );

   bme_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .inv_wheelbase    (inv_wb_ff),
      .time_step        (dt_ff),
      .inv_time_step    (inv_dt_ff),
      .req_pos_x        (req_chan.pos_x),
      .req_pos_y        (req_chan.pos_y),
      .req_heading      (req_chan.heading),
      .req_speed        (req_chan.speed),
      .req_accel_in     (req_chan.accel_in),
      .req_steer        (req_chan.steer),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_out_x        (rsp_chan.out_x),
      .rsp_out_y        (rsp_chan.out_y),
      .rsp_out_heading  (rsp_chan.out_heading),
      .rsp_rate_x       (rsp_chan.rate_x),
      .rsp_rate_y       (rsp_chan.rate_y),
      .rsp_rate_heading (rsp_chan.rate_heading),
      .rsp_out_speed    (rsp_chan.out_speed),
      .rsp_out_accel    (rsp_chan.out_accel),
      .rsp_last         (rsp_chan.last)
   );

endmodule

[rtl/bme_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, gives cos and sin in Q4.30.
// Depends on bme_pkg for the gain, the angle constants and the arctangent table.
module bme_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [23:0] angle,
   output logic               done,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);
   import bme_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [4:0]         iter_ff, iter_in;
   logic               neg_ff, neg_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [35:0] z_ff, z_in;
   logic signed [35:0] z_a, z_b, z_c;
   logic signed [35:0] atan_ext;

   always_comb begin
      z_a = 36'(angle) <<< 10;
      if (z_a > PI_Q30) z_b = z_a - TWO_PI_Q30;
      else if (z_a < -PI_Q30) z_b = z_a + TWO_PI_Q30;
      else z_b = z_a;
      neg_in = neg_ff;
      if (z_b > HALF_PI_Q30) begin
         z_c = z_b - PI_Q30;
      end else if (z_b < -HALF_PI_Q30) begin
         z_c = z_b + PI_Q30;
      end else begin
         z_c = z_b;
      end

      atan_ext = $signed({5'b0, atan_val(iter_ff)});
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         x_in = CORDIC_GAIN;
         y_in = '0;
         z_in = z_c;
         neg_in = (z_b > HALF_PI_Q30) || (z_b < -HALF_PI_Q30);
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - (y_ff >>> iter_ff);
            y_in = y_ff + (x_ff >>> iter_ff);
            z_in = z_ff - atan_ext;
         end else begin
            x_in = x_ff + (y_ff >>> iter_ff);
            y_in = y_ff - (x_ff >>> iter_ff);
            z_in = z_ff + atan_ext;
         end
         iter_in = iter_ff + 5'd1;
         if (iter_ff == 5'(TRIG_ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign done    = done_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

endmodule

[rtl/bme_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle, for the heading rate.
// Depends on bme_pkg for the dividend width.
module bme_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bme_pkg::DIV_BITS-1:0] dividend,
   input  logic [31:0]                  divisor,
   output logic                         done,
   output logic [bme_pkg::DIV_BITS-1:0] quotient
);
   import bme_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [32:0]         rem_ff, rem_in;
   logic [31:0]         dvs_ff, dvs_in;
   logic [32:0]         trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      trial = {rem_ff[31:0], quo_ff[DIV_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (busy_ff) begin
         // The dividend shifts out at the top while quotient bits enter at the bottom.
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/bme_datapath.sv]
// Datapath: pose state, shared multiplier, CORDIC and divider units, result register.
// Depends on bme_pkg, bme_cordic and bme_divider; driven by bme_control commands.
module bme_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bme_pkg::dp_cmd_type   cmd,
   output bme_pkg::dp_status_type status,
   input  logic [23:0]           inv_wheelbase,
   input  logic [23:0]           time_step,
   input  logic [23:0]           inv_time_step,
   input  logic signed [31:0]    req_pos_x,
   input  logic signed [31:0]    req_pos_y,
   input  logic signed [23:0]    req_heading,
   input  logic signed [22:0]    req_speed,
   input  logic signed [31:0]    req_accel_in,
   input  logic signed [20:0]    req_steer,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_out_x,
   output logic signed [31:0]    rsp_out_y,
   output logic signed [23:0]    rsp_out_heading,
   output logic signed [22:0]    rsp_rate_x,
   output logic signed [22:0]    rsp_rate_y,
   output logic signed [31:0]    rsp_rate_heading,
   output logic signed [22:0]    rsp_out_speed,
   output logic signed [31:0]    rsp_out_accel,
   output logic                  rsp_last
);
   import bme_pkg::*;

   logic signed [22:0] v_ff, ss_ff, rx_ff, ry_ff;
   logic signed [20:0] steer_ff;
   logic signed [31:0] px_ff, py_ff, sa_ff, rh_ff, acc_ff, nx_ff, ny_ff;
   logic signed [23:0] ph_ff, nh_ff;
   logic signed [33:0] cst_ff, snt_ff, cs_ff, sn_ff;
   logic signed [67:0] prod_ff, prod_in;
   logic               div_neg_ff;
   logic               valid_ff;

   logic signed [33:0] mul_a, mul_b, v_ext, w_val, dt_ext;
   logic signed [67:0] w_shift, h_sum, h_wrap, q_signed;
   logic signed [67:0] prod_mag;
   logic signed [23:0] trig_angle;
   logic               trig_done, div_done;
   logic signed [33:0] trig_cos, trig_sin;
   logic [DIV_BITS-1:0] div_q;

   assign v_ext   = 34'(v_ff);
   assign dt_ext  = $signed({10'b0, time_step});
   assign w_shift = prod_ff >>> 24;
   assign w_val   = w_shift[33:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_sel)
         MUL_V_INVL: begin mul_a = v_ext; mul_b = $signed({10'b0, inv_wheelbase}); end
         MUL_W_SNT:  begin mul_a = w_val; mul_b = snt_ff; end
         MUL_ACC:    begin
            mul_a = v_ext - 34'(ss_ff);
            mul_b = $signed({10'b0, inv_time_step});
         end
         MUL_V_CS:   begin mul_a = v_ext; mul_b = cs_ff; end
         MUL_V_SN:   begin mul_a = v_ext; mul_b = sn_ff; end
         MUL_RX_DT:  begin mul_a = 34'(rx_ff); mul_b = dt_ext; end
         MUL_RY_DT:  begin mul_a = 34'(ry_ff); mul_b = dt_ext; end
         MUL_RH_DT:  begin mul_a = 34'(rh_ff); mul_b = dt_ext; end
      endcase
      prod_in = mul_a * mul_b;
   end

   assign trig_angle = cmd.trig_heading ? ph_ff : 24'(steer_ff);

   bme_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.trig_start),
      .angle   (trig_angle),
      .done    (trig_done),
      .cos_out (trig_cos),
      .sin_out (trig_sin)
   );

   assign prod_mag = prod_ff[67] ? -prod_ff : prod_ff;

   bme_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_mag[DIV_BITS-1:0]),
      .divisor  (cst_ff[31:0]),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      q_signed = $signed({12'b0, div_q});
      if (div_neg_ff) q_signed = -q_signed;
      h_sum = 68'(ph_ff) + (prod_ff >>> 12);
      if (h_sum < -TWO_PI_Q20) h_wrap = h_sum + TWO_PI_Q20;
      else if (h_sum > TWO_PI_Q20) h_wrap = h_sum - TWO_PI_Q20;
      else h_wrap = h_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff    <= '0;
         py_ff    <= '0;
         ph_ff    <= '0;
         ss_ff    <= '0;
         sa_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.load_state) begin
            px_ff <= req_pos_x;
            py_ff <= req_pos_y;
            ph_ff <= req_heading;
            ss_ff <= req_speed;
            sa_ff <= req_accel_in;
         end else if (cmd.out_load) begin
            px_ff <= nx_ff;
            py_ff <= ny_ff;
            ph_ff <= nh_ff;
         end
         if (cmd.out_load) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         v_ff     <= req_speed;
         steer_ff <= req_steer;
      end
      if (cmd.mul_en) prod_ff <= prod_in;
      if (cmd.cap_trig_steer) begin
         cst_ff <= trig_cos;
         snt_ff <= trig_sin;
      end
      if (cmd.cap_trig_head) begin
         cs_ff <= trig_cos;
         sn_ff <= trig_sin;
      end
      if (cmd.div_start) div_neg_ff <= prod_ff[67];
      // A non-positive cosine of the steering angle gives no heading rate.
      if (cmd.cap_rh) rh_ff <= (cst_ff > 0) ? sat32(q_signed) : '0;
      if (cmd.cap_accel) acc_ff <= sat32(prod_ff >>> 8);
      if (cmd.cap_rx) rx_ff <= sat23(prod_ff >>> 30);
      if (cmd.cap_ry) ry_ff <= sat23(prod_ff >>> 30);
      if (cmd.cap_nx) nx_ff <= sat32(68'(px_ff) + (prod_ff >>> 16));
      if (cmd.cap_ny) ny_ff <= sat32(68'(py_ff) + (prod_ff >>> 16));
      if (cmd.cap_nh) nh_ff <= sat24(h_wrap);
      if (cmd.out_load) begin
         rsp_out_x        <= nx_ff;
         rsp_out_y        <= ny_ff;
         rsp_out_heading  <= nh_ff;
         rsp_rate_x       <= rx_ff;
         rsp_rate_y       <= ry_ff;
         rsp_rate_heading <= rh_ff;
         rsp_out_speed    <= cmd.last ? v_ff : ss_ff;
         rsp_out_accel    <= cmd.last ? acc_ff : sa_ff;
         rsp_last         <= cmd.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign status.trig_done = trig_done;
   assign status.div_done  = div_done;
   assign status.out_busy  = valid_ff & ~rsp_ready;

endmodule

[rtl/bme_control.sv]
// Controller state machine: takes load commands and sequences the setup and the Euler steps of a drive command.
// Depends on bme_pkg for the command and status structures.
module bme_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [6:0]             req_steps,
   input  bme_pkg::dp_status_type status,
   output bme_pkg::dp_cmd_type    cmd
);
   import bme_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_TRIG_S = 4'd1;
   localparam logic [3:0] ST_WAIT_S = 4'd2;
   localparam logic [3:0] ST_MUL_W  = 4'd3;
   localparam logic [3:0] ST_MUL_WS = 4'd4;
   localparam logic [3:0] ST_DIV_GO = 4'd5;
   localparam logic [3:0] ST_DIV_WT = 4'd6;
   localparam logic [3:0] ST_TRIG_H = 4'd7;
   localparam logic [3:0] ST_WAIT_H = 4'd8;
   localparam logic [3:0] ST_X1     = 4'd9;
   localparam logic [3:0] ST_X2     = 4'd10;
   localparam logic [3:0] ST_X3     = 4'd11;
   localparam logic [3:0] ST_X4     = 4'd12;
   localparam logic [3:0] ST_X5     = 4'd13;
   localparam logic [3:0] ST_X6     = 4'd14;
   localparam logic [3:0] ST_OUT    = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [6:0] count_ff, count_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      count_in = count_ff;
      cmd.last = (count_ff == 7'd1);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               if (!req_mode) begin
                  cmd.load_state = 1'b1;
               end else if (req_steps != 7'd0) begin
                  count_in = (req_steps > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : req_steps;
                  state_in = ST_TRIG_S;
               end
            end
         end
         ST_TRIG_S: begin
            cmd.trig_start = 1'b1;
            state_in = ST_WAIT_S;
         end
         ST_WAIT_S: begin
            if (status.trig_done) begin
               cmd.cap_trig_steer = 1'b1;
               state_in = ST_MUL_W;
            end
         end
         ST_MUL_W: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_V_INVL;
            state_in = ST_MUL_WS;
         end
         ST_MUL_WS: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_W_SNT;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            // The divider takes the held product while the multiplier moves on to the next one.
            cmd.div_start = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_ACC;
            state_in = ST_DIV_WT;
         end
         ST_DIV_WT: begin
            cmd.cap_accel = 1'b1;
            if (status.div_done) begin
               cmd.cap_rh = 1'b1;
               state_in = ST_TRIG_H;
            end
         end
         ST_TRIG_H: begin
            cmd.trig_start = 1'b1;
            cmd.trig_heading = 1'b1;
            state_in = ST_WAIT_H;
         end
         ST_WAIT_H: begin
            if (status.trig_done) begin
               cmd.cap_trig_head = 1'b1;
               state_in = ST_X1;
            end
         end
         ST_X1: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_V_CS;
            state_in = ST_X2;
         end
         ST_X2: begin
            cmd.cap_rx = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_V_SN;
            state_in = ST_X3;
         end
         ST_X3: begin
            cmd.cap_ry = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_RX_DT;
            state_in = ST_X4;
         end
         ST_X4: begin
            cmd.cap_nx = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_RY_DT;
            state_in = ST_X5;
         end
         ST_X5: begin
            cmd.cap_ny = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = MUL_RH_DT;
            state_in = ST_X6;
         end
         ST_X6: begin
            cmd.cap_nh = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // The pose is committed when the result enters the output register.
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               count_in = count_ff - 7'd1;
               state_in = (count_ff == 7'd1) ? ST_IDLE : ST_TRIG_H;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bicycle_model_euler_integrator: load and drive commands go in
// on a valid/ready channel, each step result is checked against a fixed-point motion predictor.
// Depends on bme_pkg, the channel interfaces in bme_if.sv and the block itself.
module testbench;
   import bme_pkg::*;

   typedef struct {
      logic               mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [23:0] heading;
      logic signed [22:0] speed;
      logic signed [31:0] accel_in;
      logic signed [20:0] steer;
      logic [6:0]         steps;
   } command_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [23:0] heading;
      logic signed [22:0] rate_x;
      logic signed [22:0] rate_y;
      logic signed [31:0] rate_heading;
      logic signed [22:0] speed;
      logic signed [31:0] accel;
      logic               last;
   } pose_result_type;

   localparam longint TWO_PI_FINE = 64'sd6588397;
   localparam longint PI_COARSE   = 64'sd3373259426;
   localparam longint HALF_PI_C   = 64'sd1686629713;
   localparam longint TWO_PI_C    = 64'sd6746518852;
   localparam longint GAIN        = 64'sd652032874;

   longint arctan_q30 [24] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bme_req_if req ();
   bme_rsp_if rsp ();

   bicycle_model_euler_integrator dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready));

   always #5 clock = ~clock;

   // Predictor state and configuration.
   longint inv_wheelbase, step_dt, inv_step_dt;
   longint veh_x, veh_y, veh_heading, veh_speed, veh_accel;
   pose_result_type expected_poses [$];
   int errors = 0, results_seen = 0, commands_sent = 0;
   int rsp_stall_pct = 20;

   function automatic longint clamp(longint v, int w);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -(64'sd1 <<< (w - 1));
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   task automatic rotate(input longint ang, output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = ang * 1024;
      x = GAIN;
      y = 0;
      flip = 0;
      if (z > PI_COARSE) z -= TWO_PI_C;
      else if (z < -PI_COARSE) z += TWO_PI_C;
      if (z > HALF_PI_C) begin
         z -= PI_COARSE;
         flip = 1;
      end else if (z < -HALF_PI_C) begin
         z += PI_COARSE;
         flip = 1;
      end
      for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_q30[i];
         end else begin
            x += dx; y -= dy; z += arctan_q30[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic predict_motion(input command_type c);
      longint v, n, cst, snt, w, rh, cs, sn, rx, ry, h;
      pose_result_type r;
      v = longint'(c.speed);
      if (!c.mode) begin
         veh_x = c.pos_x;
         veh_y = c.pos_y;
         veh_heading = c.heading;
         veh_speed = v;
         veh_accel = c.accel_in;
         return;
      end
      n = c.steps > MAX_STEPS ? MAX_STEPS : c.steps;
      if (n == 0) return;
      rotate(longint'(c.steer), cst, snt);
      w = (v * inv_wheelbase) >>> 24;
      rh = cst > 0 ? clamp((w * snt) / cst, 32) : 0;
      for (int k = 0; k < n; k++) begin
         rotate(veh_heading, cs, sn);
         rx = clamp((v * cs) >>> 30, 23);
         ry = clamp((v * sn) >>> 30, 23);
         veh_x = clamp(veh_x + ((rx * step_dt) >>> 16), 32);
         veh_y = clamp(veh_y + ((ry * step_dt) >>> 16), 32);
         h = veh_heading + ((rh * step_dt) >>> 12);
         if (h < -TWO_PI_FINE) h += TWO_PI_FINE;
         else if (h > TWO_PI_FINE) h -= TWO_PI_FINE;
         veh_heading = clamp(h, 24);
         r.x = veh_x;
         r.y = veh_y;
         r.heading = veh_heading;
         r.rate_x = rx;
         r.rate_y = ry;
         r.rate_heading = rh;
         r.last = (k == n - 1);
         if (r.last) begin
            r.speed = v;
            r.accel = clamp(((v - veh_speed) * inv_step_dt) >>> 8, 32);
         end else begin
            r.speed = veh_speed;
            r.accel = veh_accel;
         end
         expected_poses.insert(expected_poses.size(), r);
      end
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   // Result side: random stalls, and each transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      pose_result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         results_seen++;
         if (expected_poses.size() == 0) begin
            $display("%0t: result transfer with nothing expected", $time);
            errors++;
         end else begin
            e = expected_poses.pop_front();
            check_field("out_x", e.x, rsp.out_x);
            check_field("out_y", e.y, rsp.out_y);
            check_field("out_heading", e.heading, rsp.out_heading);
            check_field("rate_x", e.rate_x, rsp.rate_x);
            check_field("rate_y", e.rate_y, rsp.rate_y);
            check_field("rate_heading", e.rate_heading, rsp.rate_heading);
            check_field("out_speed", e.speed, rsp.out_speed);
            check_field("out_accel", e.accel, rsp.out_accel);
            check_field("last", e.last, rsp.last);
         end
      end
   end

   // Sends one command. Valid is kept high across back-to-back transfers.
   task automatic send_command(input command_type c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.mode <= c.mode;
      req.pos_x <= c.pos_x;
      req.pos_y <= c.pos_y;
      req.heading <= c.heading;
      req.speed <= c.speed;
      req.accel_in <= c.accel_in;
      req.steer <= c.steer;
      req.steps <= c.steps;
      do @(posedge clock); while (!req.ready);
      predict_motion(c);
      commands_sent++;
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [23:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {8'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_INV_WHEELBASE: inv_wheelbase = value;
         REG_TIME_STEP:     step_dt = value;
         REG_INV_TIME_STEP: inv_step_dt = value;
         default: ;
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [23:0] invl, input logic [23:0] dt,
                            input logic [23:0] invdt);
      write_register(REG_INV_WHEELBASE, invl);
      write_register(REG_TIME_STEP, dt);
      write_register(REG_INV_TIME_STEP, invdt);
   endtask

   function automatic command_type load_cmd(longint x, longint y, longint h, longint v,
                                            longint a);
      command_type c;
      c = '{mode: 1'b0, pos_x: x, pos_y: y, heading: h, speed: v, accel_in: a,
            steer: $urandom, steps: $urandom};
      return c;
   endfunction

   function automatic command_type drive_cmd(longint v, longint st, int n);
      command_type c;
      c = '{mode: 1'b1, pos_x: $urandom, pos_y: $urandom, heading: $urandom, speed: v,
            accel_in: $urandom, steer: st, steps: n};
      return c;
   endfunction

   function automatic command_type random_cmd();
      command_type c;
      int p;
      p = $urandom_range(99);
      c.mode = ($urandom_range(99) >= 15);
      c.pos_x = $urandom;
      c.pos_y = $urandom;
      c.heading = $urandom;
      c.speed = $urandom;
      c.accel_in = $urandom;
      c.steer = $urandom;
      if (p < 85) c.steps = $urandom_range(4, 1);
      else if (p < 96) c.steps = $urandom_range(16, 5);
      else c.steps = $urandom_range(127);
      return c;
   endfunction

   task automatic test_load_and_step();
      send_command(load_cmd(0, 0, 0, 0, 0));
      send_command(drive_cmd(65536, 0, 1));
      send_command(drive_cmd(-65536, 200000, 3));
      send_command(load_cmd(12345, -6789, 500000, 3276800, -1000));
      send_command(drive_cmd(3276800, -823550, 2));
      wait_drained();
   endtask

   task automatic test_field_extremes();
      send_command(load_cmd(64'sh7FFF_0000, -64'sh7FFF_0000, 24'sh7FFFFF, -3276800, 64'sh7FFFFFFF));
      send_command(drive_cmd(3276800, 823550, 4));
      send_command(drive_cmd(-4194304, 21'sh0FFFFF, 2));
      send_command(drive_cmd(4194303, -21'sh100000, 2));
      send_command(load_cmd(-64'sh8000_0000, 64'sh7FFF_FFFF, -24'sh800000, 4194303,
                            -64'sh8000_0000));
      send_command(drive_cmd(-3276800, 0, 3));
      send_command(drive_cmd(1, 1, 0));
      wait_drained();
   endtask

   // Pose near the limits with a fast, hard-steered vehicle exercises position saturation
   // and the single heading wrap in both directions.
   task automatic test_wrap_and_saturation();
      configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_command(load_cmd(64'sh7FFF_F000, -64'sh7FFF_F000, 6500000, 0, 0));
      send_command(drive_cmd(3276800, 823550, 5));
      send_command(load_cmd(0, 0, -6500000, 0, 0));
      send_command(drive_cmd(3276800, -823550, 5));
      send_command(drive_cmd(-3276800, 823550, 5));
      wait_drained();
      configure(1, 1, 1);
      send_command(drive_cmd(3276800, 823550, 3));
      wait_drained();
   endtask

   task automatic test_step_counts();
      configure(559241, 6554, 2560);
      send_command(drive_cmd(100000, 300000, 64));
      send_command(drive_cmd(-70000, -300000, 65));
      send_command(drive_cmd(50000, 100, 127));
      send_command(drive_cmd(50000, 100, 0));
      wait_drained();
   endtask

   task automatic test_random_commands(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 80 == 79) begin
            wait_drained();
            configure($urandom_range(24'hFFFFFF, 1), $urandom_range(24'hFFFFFF, 1),
                      $urandom_range(24'hFFFFFF, 1));
            rsp_stall_pct = $urandom_range(3) * 20;
         end
         send_command(random_cmd());
      end
      wait_drained();
   endtask

   initial begin
      inv_wheelbase = 559241;
      step_dt = 6554;
      inv_step_dt = 2560;
      veh_x = 0; veh_y = 0; veh_heading = 0; veh_speed = 0; veh_accel = 0;
      req.valid = 1'b0;
      req.mode = 1'b0;
      req.pos_x = '0; req.pos_y = '0; req.heading = '0; req.speed = '0;
      req.accel_in = '0; req.steer = '0; req.steps = '0;
      rsp.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_and_step();
      test_field_extremes();
      test_wrap_and_saturation();
      test_step_counts();
      test_random_commands(250);
      $display("Sent %0d commands (loads, drives, step counts 0..127) under several settings,",
               commands_sent);
      $display("checked %0d step results with random stalls on both channels.", results_seen);
      if (errors == 0 && expected_poses.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Timeout with %0d results still expected", expected_poses.size());
      $display("Simulation FAILED");
      $finish;
   end
endmodule

[filelist.f]
rtl/bme_pkg.sv
rtl/bme_if.sv
rtl/bme_cordic.sv
rtl/bme_divider.sv
rtl/bme_datapath.sv
rtl/bme_control.sv
rtl/bicycle_model_euler_integrator.sv
sim/testbench.sv
